### sv/htw_pkg.sv
package htw_pkg;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_DEL = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [2:0] ST_ADDED = 3'd0;
	localparam logic [2:0] ST_FULL = 3'd1;
	localparam logic [2:0] ST_DELETED = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_EXPIRED = 3'd4;
	localparam logic [2:0] ST_IDLE_TICK = 3'd5;

	localparam logic REG_SLOT_COUNT = 1'b0;
	localparam logic REG_TICK_STEP = 1'b1;

	localparam int ROUNDS_W = 31;
	localparam int TAG_W = 16;

	typedef struct packed {
		logic [1:0] operation;
		logic [30:0] timeout;
		logic [15:0] user_tag;
		logic [5:0] handle_in;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] handle_out;
		logic [15:0] tag_out;
		logic last;
	} out_item_t;

endpackage

### sv/htw_ram.sv
module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### sv/htw_div.sv
// Restoring divider, one quotient bit per cycle.
module htw_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [30:0] dividend,
	input logic [15:0] divisor,
	output logic busy,
	output logic [30:0] quotient,
	output logic [15:0] remainder
);
	import htw_pkg::*;

	logic [30:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] dvs_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [16:0] shifted;
	logic [16:0] diff;

	assign shifted = {rem_q[15:0], quo_q[30]};
	assign diff = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd30;
		end else if (busy_q) begin
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[16]) begin
				rem_q <= diff;
				quo_q <= {quo_q[29:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[29:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;
	assign remainder = rem_q[15:0];
endmodule

### sv/htw_seq.sv
// Operation sequencer: owns the entry memory ports, the valid bits and the output register.
module htw_seq #(
	parameter int MAX_TIMERS = 64,
	parameter int MAX_SLOTS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input htw_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output htw_pkg::out_item_t out_data,
	input logic [6:0] slot_count,
	input logic [15:0] tick_step
);
	import htw_pkg::*;

	localparam int HW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int EW = SW + ROUNDS_W + TAG_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV1 = 4'd1;
	localparam logic [3:0] S_DIV2 = 4'd2;
	localparam logic [3:0] S_ADDW = 4'd3;
	localparam logic [3:0] S_DELR = 4'd4;
	localparam logic [3:0] S_SCAN = 4'd5;
	localparam logic [3:0] S_OUT = 4'd6;
	localparam logic [3:0] S_DIVW1 = 4'd7;
	localparam logic [3:0] S_DIVW2 = 4'd8;
	localparam logic [3:0] S_MOD = 4'd9;
	localparam logic [3:0] S_MODW = 4'd10;

	logic [3:0] state_q;
	logic [MAX_TIMERS-1:0] valid_q;
	in_item_t item_q;
	logic [SW-1:0] cur_q;
	logic [10:0] n_q;
	logic [15:0] stp_q;
	logic [30:0] ticks_q;
	logic [ROUNDS_W-1:0] rounds_q;
	logic [HW-1:0] hnd_q;
	logic [HW:0] scan_q;
	logic scan_rd_s1;
	logic [HW-1:0] scan_h_s1;
	logic any_q;
	logic out_valid_q;
	out_item_t out_q;
	out_item_t pend_q;

	logic we;
	logic [HW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic [HW-1:0] raddr;
	logic [EW-1:0] rdata;
	logic [SW-1:0] r_slot;
	logic [ROUNDS_W-1:0] r_rounds;
	logic [TAG_W-1:0] r_tag;

	logic div_start;
	logic div_busy;
	logic [30:0] dq;
	logic [15:0] dr;
	logic [30:0] d_dividend;
	logic [15:0] d_divisor;

	logic [HW-1:0] free_h;
	logic free_any;
	logic [10:0] n_eff;
	logic [SW:0] sum;
	logic out_free;
	logic take;
	logic del_ok;
	logic hit;
	logic dec;
	logic scan_hold;
	logic scan_end;
	logic out_set;

	htw_ram #(.WIDTH(EW), .DEPTH(1 << HW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	htw_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(d_dividend), .divisor(d_divisor),
		.busy(div_busy), .quotient(dq), .remainder(dr)
	);

	assign {r_slot, r_rounds, r_tag} = rdata;

	always_comb begin
		free_h = '0;
		free_any = 1'b0;
		for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_h = HW'(i);
				free_any = 1'b1;
			end
		end
	end

	always_comb begin
		n_eff = {4'd0, slot_count};
		if (slot_count == 7'd0) begin
			n_eff = 11'd1;
		end else if ({4'd0, slot_count} > 11'(MAX_SLOTS)) begin
			n_eff = 11'(MAX_SLOTS);
		end
	end

	assign sum = (SW + 1)'(cur_q) + (SW + 1)'(dr);
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || out_valid_q;
	assign take = in_valid && !in_stall;
	assign del_ok = ({1'b0, in_data.handle_in} < 7'(MAX_TIMERS))
		&& valid_q[in_data.handle_in[HW-1:0]];

	assign hit = (state_q == S_SCAN) && scan_rd_s1 && valid_q[scan_h_s1]
		&& r_slot == cur_q && r_rounds == '0;
	assign dec = (state_q == S_SCAN) && scan_rd_s1 && valid_q[scan_h_s1]
		&& r_slot == cur_q && r_rounds != '0;
	// A second hit waits in place while the earlier one cannot leave yet.
	assign scan_hold = hit && any_q && !out_free;
	assign scan_end = (state_q == S_SCAN) && !scan_rd_s1 && scan_q >= (HW+1)'(MAX_TIMERS);

	always_comb begin
		out_set = 1'b0;
		if (state_q == S_IDLE) begin
			out_set = take && ((in_data.operation == OP_ADD && !free_any)
				|| (in_data.operation == OP_DEL && !del_ok));
		end else if (state_q == S_SCAN) begin
			out_set = hit && any_q && out_free;
		end else if (state_q == S_OUT) begin
			out_set = out_free;
		end
	end

	always_comb begin
		div_start = 1'b0;
		d_dividend = item_q.timeout;
		d_divisor = stp_q;
		if (state_q == S_DIV1) begin
			div_start = 1'b1;
		end else if (state_q == S_DIV2) begin
			div_start = 1'b1;
			d_dividend = ticks_q;
			d_divisor = 16'(n_q);
		end else if (state_q == S_MOD) begin
			div_start = 1'b1;
			d_divisor = 16'(n_q);
			if (item_q.operation == OP_TICK) begin
				d_dividend = 31'(cur_q) + 31'd1;
			end else begin
				d_dividend = 31'(sum);
			end
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = hnd_q;
		wdata = {SW'(dr), rounds_q, item_q.user_tag};
		raddr = in_data.handle_in[HW-1:0];
		if (state_q == S_ADDW) begin
			we = 1'b1;
		end else if (state_q == S_SCAN) begin
			raddr = scan_hold ? scan_h_s1 : scan_q[HW-1:0];
			if (dec) begin
				we = 1'b1;
				waddr = scan_h_s1;
				wdata = {r_slot, r_rounds - ROUNDS_W'(1), r_tag};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			cur_q <= '0;
			out_valid_q <= 1'b0;
			scan_rd_s1 <= 1'b0;
		end else begin
			out_valid_q <= out_set || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						unique case (in_data.operation)
							OP_ADD: begin
								if (free_any) begin
									state_q <= S_DIV1;
								end
							end
							OP_DEL: begin
								if (del_ok) begin
									state_q <= S_DELR;
								end
							end
							OP_TICK: state_q <= S_MOD;
							default: ;
						endcase
					end
				end
				S_DIV1: state_q <= S_DIVW1;
				S_DIVW1: if (!div_busy) begin
					state_q <= S_DIV2;
				end
				S_DIV2: state_q <= S_DIVW2;
				S_DIVW2: if (!div_busy) begin
					state_q <= S_MOD;
				end
				S_MOD: state_q <= S_MODW;
				S_MODW: if (!div_busy) begin
					if (item_q.operation == OP_TICK) begin
						cur_q <= SW'(dr);
						state_q <= S_SCAN;
					end else begin
						state_q <= S_ADDW;
					end
				end
				S_ADDW: begin
					valid_q[hnd_q] <= 1'b1;
					state_q <= S_OUT;
				end
				S_DELR: begin
					valid_q[hnd_q] <= 1'b0;
					state_q <= S_OUT;
				end
				S_SCAN: begin
					if (!scan_hold) begin
						scan_rd_s1 <= scan_q < (HW+1)'(MAX_TIMERS);
						if (hit) begin
							valid_q[scan_h_s1] <= 1'b0;
						end
					end
					if (scan_end) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				item_q <= in_data;
				n_q <= n_eff;
				stp_q <= (tick_step == 16'd0) ? 16'd1 : tick_step;
				hnd_q <= (in_data.operation == OP_DEL) ? in_data.handle_in[HW-1:0]
					: free_h;
				scan_q <= '0;
				any_q <= 1'b0;
				if (take) begin
					out_q.last <= 1'b1;
					out_q.tag_out <= '0;
					if (in_data.operation == OP_ADD) begin
						out_q.status <= ST_FULL;
						out_q.handle_out <= '0;
					end else begin
						out_q.status <= ST_NOTFOUND;
						out_q.handle_out <= in_data.handle_in;
					end
				end
			end
			S_DIVW1: begin
				ticks_q <= (item_q.timeout < 31'(stp_q)) ? 31'd1 : dq;
			end
			S_DIVW2: begin
				rounds_q <= dq;
			end
			S_ADDW: begin
				out_q.status <= ST_ADDED;
				out_q.handle_out <= 6'(hnd_q);
				out_q.tag_out <= item_q.user_tag;
			end
			S_DELR: begin
				out_q.status <= ST_DELETED;
				out_q.handle_out <= 6'(hnd_q);
				out_q.tag_out <= r_tag;
			end
			S_SCAN: begin
				if (!scan_hold) begin
					scan_h_s1 <= scan_q[HW-1:0];
					if (scan_q < (HW+1)'(MAX_TIMERS)) begin
						scan_q <= scan_q + (HW+1)'(1);
					end
					if (hit) begin
						// The newest hit waits in pend_q until the next hit or the end
						// of the scan tells whether it is the final one.
						pend_q <= {ST_EXPIRED, 6'(scan_h_s1), r_tag, 1'b0};
						any_q <= 1'b1;
						if (any_q) begin
							out_q <= pend_q;
						end
					end
				end
			end
			S_OUT: begin
				if (out_free && item_q.operation == OP_TICK) begin
					if (any_q) begin
						out_q <= {pend_q.status, pend_q.handle_out, pend_q.tag_out, 1'b1};
					end else begin
						out_q <= {ST_IDLE_TICK, 6'd0, 16'd0, 1'b1};
					end
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;
endmodule

### sv/hashed_timing_wheel.sv
// Operation: an add runs three divisions in turn before its entry is written, a delete
//   reads its entry, a full pool or unknown handle is answered without leaving idle, and a
//   tick runs one division for the new slot, then reads every entry; a stalled output can hold the scan.
// Throughput: one item at a time; the next transfer is taken once the result register
//   is empty, and a tick reads every pool entry once through the single read port.
// Reset: arst_n clears all valid bits, the current slot and the output valid flag
//   and restores slot_count to 60 and tick_step to 1; entry contents are not cleared.
module hashed_timing_wheel #(
	parameter int MAX_TIMERS = 64,
	parameter int MAX_SLOTS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input htw_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output htw_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data
);
	import htw_pkg::*;

	logic [6:0] slot_count_q;
	logic [15:0] tick_step_q;

	// Configuration registers, to be written only while the wheel is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= 7'd60;
			tick_step_q <= 16'd1;
		end else if (cfg_we) begin
			if (cfg_index == REG_SLOT_COUNT) begin
				slot_count_q <= cfg_data[6:0];
			end else begin
				tick_step_q <= cfg_data;
			end
		end
	end

	htw_seq #(.MAX_TIMERS(MAX_TIMERS), .MAX_SLOTS(MAX_SLOTS)) u_seq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.slot_count(slot_count_q), .tick_step(tick_step_q)
	);
endmodule

### sv/htw_checker.sv
module htw_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input htw_pkg::out_item_t out_data,
	input logic out_valid,
	input logic out_stall
);
	import htw_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_IDLE_TICK)
		else $error("bad status");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_EXPIRED |-> out_data.last)
		else $error("single result without last");

	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result waits");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("stalled input withdrawn");
endmodule

bind hashed_timing_wheel htw_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
);

### tb/hashed_timing_wheel_tb.sv
module hashed_timing_wheel_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import htw_pkg::*;

	localparam int POOL = 64;
	localparam int WHEEL = 64;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [15:0] cfg_data;

	hashed_timing_wheel dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the wheel: the pool of timers and the configuration.
	bit timer_live [POOL];
	bit [5:0] timer_slot [POOL];
	bit [30:0] timer_laps [POOL];
	bit [15:0] timer_tag [POOL];
	bit [5:0] cursor;
	bit [6:0] wheel_slots;
	bit [15:0] tick_units;

	in_item_t pending_ops[$];
	out_item_t expected_events[$];
	int error_count;
	int sent_count;
	bit hold_off;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what);
		$display("mismatch: %s", what);
		error_count++;
	endtask

	task automatic enqueue_op(input in_item_t it);
		pending_ops = {pending_ops, it};
	endtask

	task automatic add_expected(input out_item_t r);
		expected_events = {expected_events, r};
	endtask

	// Computes the results of one operation and updates the shadow wheel.
	task automatic predict_wheel(input in_item_t op);
		int n;
		int stp;
		int ticks;
		int free_h;
		int fired;
		out_item_t r;
		n = (wheel_slots == 0) ? 1 : (wheel_slots > WHEEL ? WHEEL : wheel_slots);
		stp = (tick_units == 0) ? 1 : tick_units;
		r = '0;
		r.last = 1'b1;
		case (op.operation)
			OP_ADD: begin
				free_h = -1;
				for (int i = POOL - 1; i >= 0; i--)
					if (!timer_live[i]) free_h = i;
				if (free_h < 0) begin
					r.status = ST_FULL;
				end else begin
					ticks = (op.timeout < stp) ? 1 : op.timeout / stp;
					timer_live[free_h] = 1'b1;
					timer_slot[free_h] = (cursor + ticks % n) % n;
					timer_laps[free_h] = ticks / n;
					timer_tag[free_h] = op.user_tag;
					r.status = ST_ADDED;
					r.handle_out = free_h;
					r.tag_out = op.user_tag;
				end
				add_expected(r);
			end
			OP_DEL: begin
				r.handle_out = op.handle_in;
				if (!timer_live[op.handle_in]) begin
					r.status = ST_NOTFOUND;
				end else begin
					timer_live[op.handle_in] = 1'b0;
					r.status = ST_DELETED;
					r.tag_out = timer_tag[op.handle_in];
				end
				add_expected(r);
			end
			OP_TICK: begin
				fired = 0;
				cursor = (cursor + 1) % n;
				for (int i = 0; i < POOL; i++) begin
					if (timer_live[i] && timer_slot[i] == cursor) begin
						if (timer_laps[i] > 0) begin
							timer_laps[i]--;
						end else begin
							if (fired > 0) expected_events[$].last = 1'b0;
							r = '0;
							r.status = ST_EXPIRED;
							r.handle_out = i;
							r.tag_out = timer_tag[i];
							r.last = 1'b1;
							add_expected(r);
							timer_live[i] = 1'b0;
							fired++;
						end
					end
				end
				if (fired == 0) begin
					r.status = ST_IDLE_TICK;
					add_expected(r);
				end
			end
			default: ;
		endcase
	endtask

	// Driver: each transfer is followed by a random gap before the next offer.
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_wheel(in_data);
				sent_count++;
				send_gap = $urandom_range(0, 8);
				if ($urandom_range(0, 3) == 0) send_gap = 0;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_ops.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compares every result transfer against the oldest prediction.
	int recv_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					report($sformatf("unexpected result %p", out_data));
				end else if (out_data !== expected_events[0]) begin
					report($sformatf("got %p want %p", out_data, expected_events[0]));
					void'(expected_events.pop_front());
				end else begin
					void'(expected_events.pop_front());
				end
				recv_gap = $urandom_range(0, 8);
				if ($urandom_range(0, 2) == 0) recv_gap = 0;
			end
			if (hold_off) begin
				out_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// The long hold-off runs in its own process while the driver keeps offering.
	initial begin
		hold_off = 1'b0;
		wait (sent_count >= 20);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (600) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic in_item_t make_op(input logic [1:0] code, input int unsigned tmo,
		input int unsigned tag, input int unsigned h);
		in_item_t it;
		it.operation = code;
		it.timeout = tmo[30:0];
		it.user_tag = tag[15:0];
		it.handle_in = h[5:0];
		return it;
	endfunction

	task automatic wait_drained();
		wait (pending_ops.size() == 0 && !in_valid);
		wait (expected_events.size() == 0);
		// An unused opcode produces nothing, so let the block finish any tick.
		repeat (POOL + 20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[15:0];
		if (idx == REG_SLOT_COUNT) wheel_slots = value[6:0];
		else tick_units = value[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random phase: mostly adds and ticks, so timers really expire; deletes target
	// handles 0 to 15, and an unused opcode now and then.
	task automatic random_phase(input int count, input int tmo_max);
		int k;
		for (int i = 0; i < count; i++) begin
			k = $urandom_range(0, 99);
			if (k < 40)
				enqueue_op(make_op(OP_ADD, $urandom_range(0, tmo_max),
					$urandom, $urandom));
			else if (k < 60)
				enqueue_op(make_op(OP_DEL, $urandom, $urandom,
					$urandom_range(0, 15)));
			else if (k < 97)
				enqueue_op(make_op(OP_TICK, $urandom, $urandom, $urandom));
			else
				enqueue_op(make_op(2'd3, $urandom, $urandom, $urandom));
		end
	endtask

	initial begin
		error_count = 0;
		sent_count = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < POOL; i++) timer_live[i] = 1'b0;
		cursor = '0;
		wheel_slots = 7'd60;
		tick_units = 16'd1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: small wheel, timeouts below one step, exact multiples, deletes of
		// free and live handles, an idle tick, an unused opcode, all-ones fields.
		write_reg(REG_SLOT_COUNT, 4);
		write_reg(REG_TICK_STEP, 2);
		enqueue_op(make_op(OP_ADD, 0, 16'hFFFF, 0));
		enqueue_op(make_op(OP_ADD, 1, 16'h0001, 63));
		enqueue_op(make_op(OP_ADD, 8, 16'h1234, 0));
		enqueue_op(make_op(OP_ADD, 32'h7FFFFFFF, 16'hAAAA, 0));
		enqueue_op(make_op(OP_DEL, 0, 0, 63));
		enqueue_op(make_op(OP_DEL, 0, 0, 3));
		enqueue_op(make_op(OP_DEL, 0, 0, 3));
		enqueue_op(make_op(2'd3, 32'h7FFFFFFF, 16'hFFFF, 63));
		for (int i = 0; i < 6; i++)
			enqueue_op(make_op(OP_TICK, 0, 0, 0));
		wait_drained();

		// Fill the pool to overflow, then expire the new timers together on one slot.
		write_reg(REG_SLOT_COUNT, 1);
		write_reg(REG_TICK_STEP, 16'hFFFF);
		for (int i = 0; i < 63; i++)
			enqueue_op(make_op(OP_ADD, $urandom_range(0, 65534), $urandom, 0));
		enqueue_op(make_op(OP_ADD, 5, 16'h5555, 0));
		enqueue_op(make_op(OP_TICK, 0, 0, 0));
		enqueue_op(make_op(OP_TICK, 0, 0, 0));
		wait_drained();

		// Out-of-range register values, then a large wheel, then a shrunk one.
		write_reg(REG_SLOT_COUNT, 0);
		write_reg(REG_TICK_STEP, 0);
		random_phase(10, 6);
		wait_drained();
		write_reg(REG_SLOT_COUNT, 127);
		write_reg(REG_TICK_STEP, 3);
		random_phase(15, 250);
		wait_drained();
		write_reg(REG_SLOT_COUNT, 5);
		write_reg(REG_TICK_STEP, 1);
		random_phase(10, 20);
		wait_drained();
		write_reg(REG_SLOT_COUNT, 64);
		random_phase(5, 100);
		wait_drained();

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
sv/htw_pkg.sv
sv/htw_ram.sv
sv/htw_div.sv
sv/htw_seq.sv
sv/hashed_timing_wheel.sv
sv/htw_checker.sv
tb/hashed_timing_wheel_tb.sv
